// File: design/aob_pkg.sv
// shared types and constants for the argb over-blend pipeline
package aob_pkg;

  // pixel layout and arithmetic widths
  localparam int PIX_W   = 32;
  localparam int CH_W    = 8;
  localparam int CHANS   = 3;            // blue, green, red
  localparam int WGT_W   = 16;           // alpha weights and the divisor
  localparam int NUM_W   = 24;           // weighted channel sums
  localparam int ALPHA_LSB = 24;

  // blend constants
  localparam logic [CH_W-1:0] OPAQUE_LIMIT = 8'd250;
  localparam logic [CH_W-1:0] FULL         = 8'hFF;

  // one quotient bit is resolved per divider stage
  localparam int DIV_STEPS = CH_W;

  typedef logic [CHANS-1:0][NUM_W-1:0] num_vec_t;
  typedef logic [CHANS-1:0][CH_W-1:0]  quo_vec_t;

  // sideband that rides along with each beat through the divider
  typedef struct packed {
    logic             bypass;   // result is a whole input pixel
    logic [PIX_W-1:0] pixel;    // pixel passed through on bypass
    logic [CH_W-1:0]  alpha;    // blended alpha for the general case
  } side_t;

endpackage

// File: design/aob_divider.sv
// pipelined restoring divider, three channel lanes sharing one divisor
module aob_divider (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             vld_in,
  input  logic [aob_pkg::WGT_W-1:0] den_in,
  input  aob_pkg::num_vec_t num_in,
  input  aob_pkg::side_t    side_in,
  output logic             vld_out,
  output aob_pkg::quo_vec_t quo_out,
  output aob_pkg::side_t    side_out
);
  import aob_pkg::*;

  // per-stage registers
  logic                 vld_r  [DIV_STEPS];
  logic [WGT_W-1:0]     den_r  [DIV_STEPS];
  num_vec_t             rem_r  [DIV_STEPS];
  quo_vec_t             quo_r  [DIV_STEPS];
  side_t                side_r [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    localparam int BIT = DIV_STEPS - 1 - k;

    logic             vld_prev;
    logic [WGT_W-1:0] den_prev;
    num_vec_t         rem_prev;
    quo_vec_t         quo_prev;
    side_t            side_prev;
    num_vec_t         rem_nxt;
    quo_vec_t         quo_nxt;
    logic [NUM_W-1:0] dsh;

    // stage input: ports for the first step, previous step otherwise
    if (k == 0) begin : g_first
      assign vld_prev  = vld_in;
      assign den_prev  = den_in;
      assign rem_prev  = num_in;
      assign quo_prev  = '0;
      assign side_prev = side_in;
    end else begin : g_next
      assign vld_prev  = vld_r[k-1];
      assign den_prev  = den_r[k-1];
      assign rem_prev  = rem_r[k-1];
      assign quo_prev  = quo_r[k-1];
      assign side_prev = side_r[k-1];
    end

    // shifted divisor for this quotient bit
    assign dsh = NUM_W'(den_prev) << BIT;

    // trial subtract on each lane
    always_comb begin
      for (int c = 0; c < CHANS; c++) begin
        if (rem_prev[c] >= dsh) begin
          rem_nxt[c] = rem_prev[c] - dsh;
          quo_nxt[c] = {quo_prev[c][CH_W-2:0], 1'b1};
        end else begin
          rem_nxt[c] = rem_prev[c];
          quo_nxt[c] = {quo_prev[c][CH_W-2:0], 1'b0};
        end
      end
    end

    // valid bit
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_prev;
      end
    end

    // payload
    always_ff @(posedge clk) begin
      if (en) begin
        den_r[k]  <= den_prev;
        rem_r[k]  <= rem_nxt;
        quo_r[k]  <= quo_nxt;
        side_r[k] <= side_prev;
      end
    end
  end

  assign vld_out  = vld_r[DIV_STEPS-1];
  assign quo_out  = quo_r[DIV_STEPS-1];
  assign side_out = side_r[DIV_STEPS-1];

endmodule

// File: design/argb_alpha_over_blend.sv
// non-premultiplied argb8888 over blend, fully pipelined
// pipeline: 4 front stages, then 8 divider stages, from input beat to result beat
// throughput: one pixel per cycle; every stage advances when the output register is
//   empty or being taken, so a stall holds the whole pipe in place
// reset: synchronous active-low rst_n clears the stage valid bits only
module argb_alpha_over_blend (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_fg_argb,
  input  logic [31:0] in_bg_argb,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_argb
);
  import aob_pkg::*;

  logic adv;

  // stage 1: input register
  logic             s1_vld_r;
  logic [PIX_W-1:0] s1_fg_r, s1_bg_r;

  // stage 2: bypass decode and alpha weights
  logic             s2_vld_r;
  side_t            s2_side_r, s2_side_nxt;
  logic [WGT_W-1:0] s2_wf_r, s2_wb_r, s2_wf_nxt, s2_wb_nxt;
  quo_vec_t         s2_cf_r, s2_cb_r;

  // stage 3: weighted channel products and divisor
  logic             s3_vld_r;
  side_t            s3_side_r;
  num_vec_t         s3_pf_r, s3_pb_r, s3_pf_nxt, s3_pb_nxt;
  logic [WGT_W-1:0] s3_den_r, s3_den_nxt;

  // stage 4: numerators and blended alpha
  logic             s4_vld_r;
  side_t            s4_side_r, s4_side_nxt;
  num_vec_t         s4_num_r, s4_num_nxt;
  logic [WGT_W-1:0] s4_den_r;
  logic [WGT_W:0]   alpha_sum;

  // divider outputs
  logic             dv_vld;
  quo_vec_t         dv_quo;
  side_t            dv_side;

  logic [CH_W-1:0]  fa, ba;

  // whole pipe moves when the output register can take a beat
  assign adv      = out_ready || !out_valid;
  assign in_ready = adv;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_valid;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
    end
  end

  // stage 2 logic: special cases and 8x8 weights
  assign fa = s1_fg_r[ALPHA_LSB +: CH_W];
  assign ba = s1_bg_r[ALPHA_LSB +: CH_W];

  always_comb begin
    s2_side_nxt.alpha = '0;
    priority if (ba == '0 || fa > OPAQUE_LIMIT) begin
      s2_side_nxt.bypass = 1'b1;
      s2_side_nxt.pixel  = s1_fg_r;
    end else if (fa == '0) begin
      s2_side_nxt.bypass = 1'b1;
      s2_side_nxt.pixel  = s1_bg_r;
    end else begin
      s2_side_nxt.bypass = 1'b0;
      s2_side_nxt.pixel  = s1_fg_r;
    end
    // 255 * fa as shift and subtract
    s2_wf_nxt = {fa, {CH_W{1'b0}}} - WGT_W'(fa);
    s2_wb_nxt = WGT_W'(ba) * WGT_W'(FULL - fa);
  end

  // stage 3 logic: 16x8 products per channel, divisor sum
  // in the general case den stays within 255*255, so 16 bits hold it
  always_comb begin
    for (int c = 0; c < CHANS; c++) begin
      s3_pf_nxt[c] = NUM_W'(s2_wf_r) * NUM_W'(s2_cf_r[c]);
      s3_pb_nxt[c] = NUM_W'(s2_wb_r) * NUM_W'(s2_cb_r[c]);
    end
    s3_den_nxt = s2_wf_r + s2_wb_r;
  end

  // stage 4 logic: channel numerators and den / 255 by reciprocal trick
  always_comb begin
    for (int c = 0; c < CHANS; c++) begin
      s4_num_nxt[c] = s3_pf_r[c] + s3_pb_r[c];
    end
    alpha_sum         = {1'b0, s3_den_r} + (WGT_W+1)'(s3_den_r >> CH_W) + (WGT_W+1)'(1);
    s4_side_nxt       = s3_side_r;
    s4_side_nxt.alpha = alpha_sum[CH_W +: CH_W];
  end

  // payload registers of the front stages
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_fg_r   <= in_fg_argb;
      s1_bg_r   <= in_bg_argb;
      s2_side_r <= s2_side_nxt;
      s2_wf_r   <= s2_wf_nxt;
      s2_wb_r   <= s2_wb_nxt;
      for (int c = 0; c < CHANS; c++) begin
        s2_cf_r[c] <= s1_fg_r[CH_W*c +: CH_W];
        s2_cb_r[c] <= s1_bg_r[CH_W*c +: CH_W];
      end
      s3_side_r <= s2_side_r;
      s3_pf_r   <= s3_pf_nxt;
      s3_pb_r   <= s3_pb_nxt;
      s3_den_r  <= s3_den_nxt;
      s4_side_r <= s4_side_nxt;
      s4_num_r  <= s4_num_nxt;
      s4_den_r  <= s3_den_r;
    end
  end

  // one quotient bit per stage for each color channel
  aob_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .vld_in   (s4_vld_r),
    .den_in   (s4_den_r),
    .num_in   (s4_num_r),
    .side_in  (s4_side_r),
    .vld_out  (dv_vld),
    .quo_out  (dv_quo),
    .side_out (dv_side)
  );

  // result beat from the last divider stage
  assign out_valid = dv_vld;
  assign out_argb  = dv_side.bypass ? dv_side.pixel
                                    : {dv_side.alpha, dv_quo[2], dv_quo[1], dv_quo[0]};

endmodule

// File: tb/sv/argb_blend_checker.sv
// checker for the argb over-blend: predicts each blended pixel and compares the output beats
`timescale 1ns / 100ps

module argb_blend_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] in_fg_argb,
  input  logic [31:0] in_bg_argb,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_argb,
  output int unsigned fail_cnt,
  output int unsigned pending_cnt
);
  import aob_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] fg;
    logic [PIX_W-1:0] bg;
    logic [PIX_W-1:0] px;
  } blend_exp_t;

  // pixels predicted from accepted input beats, oldest first
  blend_exp_t blended_q[$];

  // non-premultiplied over, exact rational arithmetic with truncation
  function automatic logic [PIX_W-1:0] blend_over(input logic [PIX_W-1:0] fg,
                                                  input logic [PIX_W-1:0] bg);
    int unsigned fa;
    int unsigned ba;
    int unsigned full_w;
    int unsigned wf;
    int unsigned wb;
    int unsigned den;
    int unsigned oa;
    int unsigned v;
    logic [PIX_W-1:0] px;
    fa     = 32'(fg[ALPHA_LSB +: CH_W]);
    ba     = 32'(bg[ALPHA_LSB +: CH_W]);
    full_w = 32'(FULL);
    // transparent background or nearly opaque foreground pass the foreground
    if (ba == 0 || fa > 32'(OPAQUE_LIMIT)) return fg;
    // transparent foreground passes the background
    if (fa == 0) return bg;
    wf  = full_w * fa;
    wb  = ba * (full_w - fa);
    den = wf + wb;
    oa  = den / full_w;
    if (oa > full_w) oa = full_w;
    px = '0;
    px[ALPHA_LSB +: CH_W] = oa[CH_W-1:0];
    for (int c = 0; c < CHANS; c++) begin
      v = (wf * 32'(fg[c*CH_W +: CH_W]) + wb * 32'(bg[c*CH_W +: CH_W])) / den;
      if (v > full_w) v = full_w;
      px[c*CH_W +: CH_W] = v[CH_W-1:0];
    end
    return px;
  endfunction

  initial begin
    fail_cnt    = 0;
    pending_cnt = 0;
  end

  // predict on input beats, compare on output beats
  always @(posedge clk) begin
    blend_exp_t head;
    if (!rst_n) begin
      blended_q.delete();
    end else begin
      if (in_valid && in_ready)
        blended_q.push_back({in_fg_argb, in_bg_argb, blend_over(in_fg_argb, in_bg_argb)});
      if (out_valid && out_ready) begin
        if (blended_q.size() == 0) begin
          if (fail_cnt < 10)
            $display("%0t: unexpected output beat %08h", $realtime, out_argb);
          fail_cnt++;
        end else begin
          head = blended_q.pop_front();
          if (out_argb !== head.px) begin
            if (fail_cnt < 10)
              $display("%0t: fg %08h bg %08h: expected %08h, got %08h",
                       $realtime, head.fg, head.bg, head.px, out_argb);
            fail_cnt++;
          end
        end
      end
    end
    pending_cnt = blended_q.size();
  end

endmodule

// File: tb/sv/tb_argb_alpha_over_blend.sv
// testbench top for the argb over-blend: clock, reset, pixel stimulus and verdict
`timescale 1ns / 100ps

module tb_argb_alpha_over_blend;
  import aob_pkg::*;

  localparam int RAND_PIXELS = 2000;
  localparam int PHASES      = 3;
  localparam int HOLD_CYCLES = 100;
  localparam int SETTLE      = 24;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic        in_ready;
  logic [31:0] in_fg_argb = '0;
  logic [31:0] in_bg_argb = '0;
  logic        out_valid;
  logic        out_ready  = 1'b0;
  logic [31:0] out_argb;

  int unsigned fail_cnt;
  int unsigned pending_cnt;
  int unsigned send_idle_pct = 31;
  int unsigned recv_idle_pct = 63;
  logic        hold_rx       = 1'b0;

  argb_alpha_over_blend i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_fg_argb (in_fg_argb),
    .in_bg_argb (in_bg_argb),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_argb   (out_argb)
  );

  argb_blend_checker i_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_fg_argb  (in_fg_argb),
    .in_bg_argb  (in_bg_argb),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_argb    (out_argb),
    .fail_cnt    (fail_cnt),
    .pending_cnt (pending_cnt)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // receiver: random stalls, or a long hold-off when requested
  always @(negedge clk) begin
    out_ready <= !hold_rx && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // offer one pixel pair, with a random gap before it, until the beat is taken
  task automatic send_pixel(input logic [31:0] fg, input logic [31:0] bg);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid   <= 1'b1;
    in_fg_argb <= fg;
    in_bg_argb <= bg;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // stop offering and wait until every predicted pixel has come out
  task automatic drain_pixels();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_cnt != 0);
  endtask

  // alpha mix that favors the general case but keeps hitting each pass-through
  function automatic logic [31:0] rand_fg();
    int unsigned r;
    logic [7:0]  a;
    r = $urandom_range(0, 99);
    if (r < 8)       a = 8'd0;
    else if (r < 16) a = 8'($urandom_range(251, 255));
    else if (r < 22) a = ($urandom_range(0, 1) != 0) ? 8'd1 : OPAQUE_LIMIT;
    else             a = 8'($urandom_range(1, 250));
    if (r >= 95) return $urandom();
    return {a, 24'($urandom())};
  endfunction

  function automatic logic [31:0] rand_bg();
    int unsigned r;
    logic [7:0]  a;
    r = $urandom_range(0, 99);
    if (r < 8)       a = 8'd0;
    else if (r < 16) a = FULL;
    else             a = 8'($urandom_range(1, 255));
    if (r >= 95) return $urandom();
    return {a, 24'($urandom())};
  endfunction

  initial begin
    rst_n = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: alpha extremes, pass-through cases and channel extremes
    send_pixel(32'h0000_0000, 32'h0000_0000);
    send_pixel(32'hFFFF_FFFF, 32'h0000_0000);
    send_pixel(32'h8012_3456, 32'h00AB_CDEF);
    send_pixel(32'hFF00_00FF, 32'hFFFF_FF00);
    send_pixel(32'hFB11_2233, 32'h8044_5566);
    send_pixel(32'hFA11_2233, 32'h8044_5566);
    send_pixel(32'h0012_3456, 32'hFFAB_CDEF);
    send_pixel(32'h0000_0000, 32'hFFFF_FFFF);
    send_pixel(32'h01FF_FFFF, 32'hFF00_0000);
    send_pixel(32'h0100_0000, 32'hFFFF_FFFF);
    send_pixel(32'h01FF_00FF, 32'h0100_FF00);
    send_pixel(32'hFAFF_FFFF, 32'h0100_0000);
    send_pixel(32'hFA00_0000, 32'hFFFF_FFFF);
    send_pixel(32'h7F80_7F80, 32'h807F_807F);
    send_pixel(32'h80FF_FFFF, 32'h80FF_FFFF);
    send_pixel(32'h8000_0000, 32'h8000_0000);
    send_pixel(32'hFEA5_5A3C, 32'h01C3_3C96);
    send_pixel(32'h01A5_5A3C, 32'h01C3_3C96);
    send_pixel(32'h5555_5555, 32'hAAAA_AAAA);
    send_pixel(32'hAAAA_AAAA, 32'h5555_5555);
    drain_pixels();

    // random pixels in three idling regimes
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 31;
          recv_idle_pct <= 63;
        end
        1: begin
          send_idle_pct = 63;
          recv_idle_pct <= 31;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
          // long receiver hold-off while the sender keeps offering
          fork
            begin
              hold_rx <= 1'b1;
              repeat (HOLD_CYCLES) @(negedge clk);
              hold_rx <= 1'b0;
            end
          join_none
        end
      endcase
      for (int n = 0; n < RAND_PIXELS / PHASES; n++)
        send_pixel(rand_fg(), rand_bg());
      drain_pixels();
    end

    repeat (SETTLE) @(negedge clk);
    if (fail_cnt == 0 && pending_cnt == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
